FILE: design/lpc_host_cycle_master_defines.svh
// ---------------------------------------------------------------------------
// LPC host cycle master assertion macros
// Shared property forms for the port checker; clock aclk, reset aresetn.
// ---------------------------------------------------------------------------
`ifndef LPC_HOST_CYCLE_MASTER_DEFINES_SVH
`define LPC_HOST_CYCLE_MASTER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LHCM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define LHCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lhcm_pkg.sv
// ---------------------------------------------------------------------------
// LPC host cycle master package
// Beat types, command queue constants and bus phase encoding.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lhcm_pkg;

    // Operation codes of an input beat
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // LPC nibble constants
    localparam logic [3:0] NIB_START  = 4'h0;
    localparam logic [3:0] NIB_TAR    = 4'hf;
    localparam logic [3:0] SYNC_READY = 4'h0;

    localparam logic [7:0] SYNC_LIMIT_RST = 8'd20;
    localparam logic [7:0] SYNC_CNT_MAX   = 8'hff;

    // Address nibble counts
    localparam logic [3:0] NIBS_MEM = 4'd8;
    localparam logic [3:0] NIBS_IO  = 4'd4;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic        operation;
        logic [1:0]  cycle_kind;
        logic [31:0] address;
        logic [7:0]  write_data;
        logic [3:0]  lad_in;
    } item_t;

    typedef struct packed {
        logic [3:0] lad_out;
        logic       lad_drive;
        logic       frame_n;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       sync_timeout;
    } result_t;

    // Classified command handed from front to back
    typedef struct packed {
        logic        is_start;
        logic        is_mem;
        logic        is_write;
        logic [31:0] address;
        logic [7:0]  wdata;
        logic [3:0]  lad;
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_START = 4'd1,
        PH_CTYPE = 4'd2,
        PH_ADDR  = 4'd3,
        PH_WDATA = 4'd4,
        PH_HTAR  = 4'd5,
        PH_SYNC  = 4'd6,
        PH_RDATA = 4'd7,
        PH_PTAR  = 4'd8
    } phase_t;

endpackage

FILE: design/lpc_host_cycle_master.sv
// A beat accepted into the command queue is stepped by the bus engine, which
// registers its result beat. Throughput: one beat per clock when the result
// channel is not stalled; the engine steps one command per cycle out of a
// two-entry command queue; the result register drains while the next is stepped.
// Reset: synchronous, active low; the engine returns to idle, the queue
// empties, no result is pending and sync_limit returns to 20.
// ---------------------------------------------------------------------------
// LPC host cycle master
// Runs LPC io and memory cycles, one LAD nibble per tick beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpc_host_cycle_master (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  lhcm_pkg::item_t     s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output lhcm_pkg::result_t   m_result
);
    import lhcm_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    // Accept and classify beats
    lhcm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    // Run the bus cycle
    lhcm_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

endmodule

FILE: design/lhcm_front.sv
// ---------------------------------------------------------------------------
// LPC host cycle master front end
// Accepts input beats, classifies them into commands and queues them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lhcm_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lhcm_pkg::item_t     s_item,
    output logic                q_valid,
    output lhcm_pkg::cmd_t      q_cmd,
    input  logic                q_pop
);
    import lhcm_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;
    cmd_t              cmd_in;

    // Classify the incoming beat
    always_comb begin
        cmd_in.is_start = (s_item.operation == OP_START);
        cmd_in.is_mem   = s_item.cycle_kind[1];
        cmd_in.is_write = s_item.cycle_kind[0];
        cmd_in.address  = s_item.address;
        cmd_in.wdata    = s_item.write_data;
        cmd_in.lad      = s_item.lad_in;
    end

    assign s_ready = (count_reg != QCNT_W'(QDEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_cmd   = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the command beat
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: design/lhcm_engine.sv
// ---------------------------------------------------------------------------
// LPC host cycle master bus engine
// Steps the LPC cycle one command per unstalled clock and registers the result beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lhcm_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                q_valid,
    input  lhcm_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output lhcm_pkg::result_t   m_result
);
    import lhcm_pkg::*;

    phase_t      phase_reg,     phase_next;
    logic [3:0]  nib_cnt_reg,   nib_cnt_next;
    logic [31:0] held_addr_reg, held_addr_next;
    logic [7:0]  held_data_reg, held_data_next;
    logic        held_mem_reg,  held_mem_next;
    logic        held_write_reg, held_write_next;
    logic [7:0]  sync_cnt_reg,  sync_cnt_next;
    logic        timeout_reg,   timeout_next;
    logic [7:0]  sync_limit_reg;
    logic        m_valid_reg;
    result_t     res_reg,       res_next;
    logic        fire;
    logic [3:0]  nib_inc;
    logic [3:0]  nib_dec;
    logic [7:0]  sync_inc;
    logic [31:0] addr_shifted;

    // Step when a command waits and the output slot is free or draining
    assign fire    = q_valid && (!m_valid_reg || m_ready);
    assign q_pop   = fire;
    assign m_valid = m_valid_reg;
    assign m_result = res_reg;

    assign nib_inc      = nib_cnt_reg + 4'd1;
    assign nib_dec      = nib_cnt_reg - 4'd1;
    assign sync_inc     = (sync_cnt_reg < SYNC_CNT_MAX) ? sync_cnt_reg + 8'd1 : sync_cnt_reg;
    assign addr_shifted = held_addr_reg >> {nib_dec[2:0], 2'b00};

    // Next state and result of one command
    always_comb begin
        phase_next      = phase_reg;
        nib_cnt_next    = nib_cnt_reg;
        held_addr_next  = held_addr_reg;
        held_data_next  = held_data_reg;
        held_mem_next   = held_mem_reg;
        held_write_next = held_write_reg;
        sync_cnt_next   = sync_cnt_reg;
        timeout_next    = timeout_reg;

        res_next.lad_out   = '0;
        res_next.lad_drive = 1'b0;
        res_next.frame_n   = 1'b1;
        res_next.done_res  = 1'b0;
        res_next.read_data = '0;

        if (q_cmd.is_start) begin
            // Load a new cycle only from idle; drop it otherwise
            if (phase_reg == PH_IDLE) begin
                held_mem_next   = q_cmd.is_mem;
                held_write_next = q_cmd.is_write;
                held_addr_next  = q_cmd.address;
                held_data_next  = q_cmd.wdata;
                nib_cnt_next    = '0;
                sync_cnt_next   = '0;
                timeout_next    = 1'b0;
                phase_next      = PH_START;
            end
        end else begin
            case (phase_reg)
                PH_START: begin
                    res_next.lad_out   = NIB_START;
                    res_next.lad_drive = 1'b1;
                    res_next.frame_n   = 1'b0;
                    phase_next         = PH_CTYPE;
                end
                PH_CTYPE: begin
                    res_next.lad_out   = {1'b0, held_mem_reg, held_write_reg, 1'b0};
                    res_next.lad_drive = 1'b1;
                    nib_cnt_next       = held_mem_reg ? NIBS_MEM : NIBS_IO;
                    phase_next         = PH_ADDR;
                end
                PH_ADDR: begin
                    res_next.lad_out   = addr_shifted[3:0];
                    res_next.lad_drive = 1'b1;
                    nib_cnt_next       = nib_dec;
                    if (nib_dec == 4'd0 || nib_dec > NIBS_MEM) begin
                        nib_cnt_next = '0;
                        phase_next   = held_write_reg ? PH_WDATA : PH_HTAR;
                    end
                end
                PH_WDATA: begin
                    res_next.lad_out   = (nib_cnt_reg == 4'd0) ? held_data_reg[3:0]
                                                               : held_data_reg[7:4];
                    res_next.lad_drive = 1'b1;
                    nib_cnt_next       = nib_inc;
                    if (nib_inc >= 4'd2) begin
                        nib_cnt_next = '0;
                        phase_next   = PH_HTAR;
                    end
                end
                PH_HTAR: begin
                    res_next.lad_out   = NIB_TAR;
                    res_next.lad_drive = 1'b1;
                    nib_cnt_next       = nib_inc;
                    if (nib_inc >= 4'd2) begin
                        nib_cnt_next  = '0;
                        sync_cnt_next = '0;
                        phase_next    = PH_SYNC;
                    end
                end
                PH_SYNC: begin
                    // Leave on ready sync, or flag a timeout at the limit
                    if (q_cmd.lad == SYNC_READY) begin
                        nib_cnt_next = '0;
                        phase_next   = held_write_reg ? PH_PTAR : PH_RDATA;
                    end else begin
                        sync_cnt_next = sync_inc;
                        if (sync_inc >= sync_limit_reg) begin
                            timeout_next = 1'b1;
                            nib_cnt_next = '0;
                            phase_next   = held_write_reg ? PH_PTAR : PH_RDATA;
                        end
                    end
                end
                PH_RDATA: begin
                    // Capture low nibble first
                    if (nib_cnt_reg == 4'd0) begin
                        held_data_next = {4'h0, q_cmd.lad};
                    end else begin
                        held_data_next = {q_cmd.lad, held_data_reg[3:0]};
                    end
                    nib_cnt_next = nib_inc;
                    if (nib_inc >= 4'd2) begin
                        nib_cnt_next = '0;
                        phase_next   = PH_PTAR;
                    end
                end
                PH_PTAR: begin
                    nib_cnt_next = nib_inc;
                    if (nib_inc >= 4'd2) begin
                        nib_cnt_next      = '0;
                        phase_next        = PH_IDLE;
                        res_next.done_res = 1'b1;
                        if (!held_write_reg) begin
                            res_next.read_data = held_data_reg;
                        end
                    end
                end
                default: begin
                    phase_next   = PH_IDLE;
                    nib_cnt_next = '0;
                end
            endcase
        end

        res_next.busy_res     = (phase_next != PH_IDLE);
        res_next.sync_timeout = timeout_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            nib_cnt_reg  <= '0;
            sync_cnt_reg <= '0;
            timeout_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg    <= phase_next;
                nib_cnt_reg  <= nib_cnt_next;
                sync_cnt_reg <= sync_cnt_next;
                timeout_reg  <= timeout_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    // Sync limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_limit_reg <= SYNC_LIMIT_RST;
        end else if (cfg_we) begin
            sync_limit_reg <= cfg_wdata;
        end
    end

    // Held cycle payload and result beat
    always_ff @(posedge aclk) begin
        if (fire) begin
            held_addr_reg  <= held_addr_next;
            held_data_reg  <= held_data_next;
            held_mem_reg   <= held_mem_next;
            held_write_reg <= held_write_next;
            res_reg        <= res_next;
        end
    end

endmodule

FILE: design/lhcm_checker.sv
// ---------------------------------------------------------------------------
// LPC host cycle master port checker
// Watches the result channel for protocol and cycle-framing slips.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lpc_host_cycle_master_defines.svh"

module lhcm_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                m_valid,
    input  logic                m_ready,
    input  lhcm_pkg::result_t   m_result
);
    import lhcm_pkg::*;

    // Hold a stalled result beat
    `LHCM_ASSERT_NEXT(a_hold_result, m_valid && !m_ready, m_valid && $stable(m_result), "result beat changed while stalled")

    // START nibble: frame low, host drives zero, cycle running
    `LHCM_ASSERT_NOW(a_start_frame, m_valid && !m_result.frame_n, m_result.lad_drive && (m_result.lad_out == NIB_START) && m_result.busy_res, "bad START beat")

    // A completing cycle leaves the bus idle and undriven
    `LHCM_ASSERT_NOW(a_done_idle, m_valid && m_result.done_res, !m_result.busy_res && !m_result.lad_drive, "done while busy or driving")

    // Read data only appears with done
    `LHCM_ASSERT_NOW(a_rdata_done, m_valid && !m_result.done_res, m_result.read_data == 8'h00, "read data without done")

endmodule

bind lpc_host_cycle_master lhcm_checker u_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LPC host cycle master testbench
// Drives start and tick beats through the valid/ready input channel and checks
// every result beat against a table want or a cycle-accurate engine mirror. A
// short directed table opens the run, then random io and memory cycles follow
// under several sync_limit settings, with random gaps on both sides.
// ---------------------------------------------------------------------------

module tb_top;
    import lhcm_pkg::*;

    // Cycle kinds of a start beat
    localparam logic [1:0] KIND_IO_RD  = 2'd0;
    localparam logic [1:0] KIND_MEM_WR = 2'd3;

    // Cycle-type nibbles read straight off the LPC definition
    localparam logic [3:0] CT_IO_READ   = 4'h0;
    localparam logic [3:0] CT_MEM_WRITE = 4'h6;

    localparam int MAX_GAP     = 19;
    localparam int PHASE_BEATS = 120;
    localparam int TAIL_CYCLES = 10;
    localparam int DRAIN_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;

    // Mirror of the bus engine state
    typedef struct {
        phase_t      phase;
        logic [3:0]  nib;
        logic [31:0] addr;
        logic [7:0]  data;
        logic [1:0]  kind;
        logic [7:0]  sync_cnt;
        logic        tmo;
        logic [7:0]  limit;
    } engine_t;

    // One directed beat with its optional hand-written result
    typedef struct packed {
        item_t   beat;
        logic    checked;
        result_t want;
    } row_t;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    item_t    s_item    = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    result_t  m_result;

    // Hand-written result travelling with the beat on the input channel
    logic     beat_checked = 1'b0;
    result_t  beat_want    = '0;

    engine_t  plan_engine;
    engine_t  mirror_engine;
    result_t  want_beats[$];
    int       fault_count = 0;
    bit       src_calm = 1'b0;
    bit       snk_calm = 1'b0;

    lpc_host_cycle_master dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic engine_t engine_reset();
        engine_t e;
        e.phase    = PH_IDLE;
        e.nib      = 4'd0;
        e.addr     = 32'h0;
        e.data     = 8'h00;
        e.kind     = 2'd0;
        e.sync_cnt = 8'h00;
        e.tmo      = 1'b0;
        e.limit    = SYNC_LIMIT_RST;
        return e;
    endfunction

    // Leave the sync wait: reads capture data, writes go straight to turnaround
    function automatic void leave_sync(inout engine_t e);
        e.nib   = 4'd0;
        e.phase = e.kind[0] ? PH_PTAR : PH_RDATA;
    endfunction

    // Advance the mirror by one beat and work out the result beat it gives
    function automatic void lpc_cycle_step(inout engine_t e, input item_t b,
                                           output result_t r);
        logic [3:0] lad;
        logic [3:0] nm1;
        logic [4:0] sh;
        logic       drive;
        logic       frame;
        logic       done;
        logic [7:0] rdata;
        lad   = 4'h0;
        drive = 1'b0;
        frame = 1'b1;
        done  = 1'b0;
        rdata = 8'h00;
        if (b.operation == OP_START) begin
            // A start while busy is dropped
            if (e.phase == PH_IDLE) begin
                e.kind     = b.cycle_kind;
                e.addr     = b.address;
                e.data     = b.write_data;
                e.nib      = 4'd0;
                e.sync_cnt = 8'h00;
                e.tmo      = 1'b0;
                e.phase    = PH_START;
            end
        end else begin
            case (e.phase)
                PH_START: begin
                    lad     = NIB_START;
                    drive   = 1'b1;
                    frame   = 1'b0;
                    e.phase = PH_CTYPE;
                end
                PH_CTYPE: begin
                    // Cycle-type nibble is the kind shifted up one place
                    lad     = {1'b0, e.kind, 1'b0};
                    drive   = 1'b1;
                    e.nib   = e.kind[1] ? NIBS_MEM : NIBS_IO;
                    e.phase = PH_ADDR;
                end
                PH_ADDR: begin
                    nm1   = e.nib - 4'd1;
                    sh    = {nm1[2:0], 2'b00};
                    lad   = e.addr[sh +: 4];
                    drive = 1'b1;
                    e.nib = nm1;
                    if (nm1 == 4'd0 || nm1 > NIBS_MEM) begin
                        e.nib   = 4'd0;
                        e.phase = e.kind[0] ? PH_WDATA : PH_HTAR;
                    end
                end
                PH_WDATA: begin
                    lad   = (e.nib == 4'd0) ? e.data[3:0] : e.data[7:4];
                    drive = 1'b1;
                    e.nib = e.nib + 4'd1;
                    if (e.nib >= 4'd2) begin
                        e.nib   = 4'd0;
                        e.phase = PH_HTAR;
                    end
                end
                PH_HTAR: begin
                    lad   = NIB_TAR;
                    drive = 1'b1;
                    e.nib = e.nib + 4'd1;
                    if (e.nib >= 4'd2) begin
                        e.nib      = 4'd0;
                        e.sync_cnt = 8'h00;
                        e.phase    = PH_SYNC;
                    end
                end
                PH_SYNC: begin
                    // Count non-ready ticks; a limit of zero acts as one
                    if (b.lad_in == SYNC_READY) begin
                        leave_sync(e);
                    end else begin
                        if (e.sync_cnt < SYNC_CNT_MAX) e.sync_cnt = e.sync_cnt + 8'd1;
                        if (e.sync_cnt >= e.limit) begin
                            e.tmo = 1'b1;
                            leave_sync(e);
                        end
                    end
                end
                PH_RDATA: begin
                    if (e.nib == 4'd0) e.data = {4'h0, b.lad_in};
                    else               e.data = {b.lad_in, e.data[3:0]};
                    e.nib = e.nib + 4'd1;
                    if (e.nib >= 4'd2) begin
                        e.nib   = 4'd0;
                        e.phase = PH_PTAR;
                    end
                end
                PH_PTAR: begin
                    e.nib = e.nib + 4'd1;
                    if (e.nib >= 4'd2) begin
                        e.nib   = 4'd0;
                        e.phase = PH_IDLE;
                        done    = 1'b1;
                        if (!e.kind[0]) rdata = e.data;
                    end
                end
                default: begin
                    e.phase = PH_IDLE;
                    e.nib   = 4'd0;
                end
            endcase
        end
        r.lad_out      = lad;
        r.lad_drive    = drive;
        r.frame_n      = frame;
        r.busy_res     = (e.phase != PH_IDLE);
        r.done_res     = done;
        r.read_data    = rdata;
        r.sync_timeout = e.tmo;
    endfunction

    function automatic result_t res(logic [3:0] lad, logic drive, logic frame, logic busy,
                                    logic done, logic [7:0] rdata, logic tmo);
        result_t r;
        r.lad_out      = lad;
        r.lad_drive    = drive;
        r.frame_n      = frame;
        r.busy_res     = busy;
        r.done_res     = done;
        r.read_data    = rdata;
        r.sync_timeout = tmo;
        return r;
    endfunction

    function automatic item_t start_beat(logic [1:0] kind, logic [31:0] addr,
                                         logic [7:0] data);
        item_t b;
        b.operation  = OP_START;
        b.cycle_kind = kind;
        b.address    = addr;
        b.write_data = data;
        b.lad_in     = 4'h0;
        return b;
    endfunction

    function automatic item_t tick_beat(logic [3:0] lad);
        item_t b;
        b            = '0;
        b.operation  = OP_TICK;
        b.lad_in     = lad;
        return b;
    endfunction

    function automatic row_t row(item_t b, logic chk, result_t w);
        row_t t;
        t.beat    = b;
        t.checked = chk;
        t.want    = w;
        return t;
    endfunction

    function automatic item_t random_item();
        item_t b;
        b.operation  = 1'($urandom_range(0, 1));
        b.cycle_kind = 2'($urandom_range(0, 3));
        b.address    = $urandom;
        b.write_data = 8'($urandom_range(0, 255));
        b.lad_in     = 4'($urandom_range(0, 15));
        return b;
    endfunction

    // Idle gap before the next beat; now and then switch to a no-gap stretch
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic string show(result_t r);
        return $sformatf("lad=%h drv=%b frm=%b busy=%b done=%b rd=%h tmo=%b",
                         r.lad_out, r.lad_drive, r.frame_n, r.busy_res,
                         r.done_res, r.read_data, r.sync_timeout);
    endfunction

    // Present one beat after a random gap and hold it until accepted
    task automatic send_beat(input item_t b, input logic chk, input result_t w);
        result_t scratch;
        int      gap;
        gap = draw_gap(src_calm);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_item       <= b;
        beat_checked <= chk;
        beat_want    <= w;
        lpc_cycle_step(plan_engine, b, scratch);
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
    endtask

    // Write sync_limit once every result beat has come back
    task automatic write_limit(input logic [7:0] v);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (want_beats.size() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        plan_engine.limit   = v;
        mirror_engine.limit = v;
    endtask

    // Mostly whole cycles with random content, some idle ticks and stray starts
    task automatic run_random(input int budget);
        int      counted;
        int      ready_pct;
        item_t   b;
        result_t none;
        counted   = 0;
        ready_pct = 50;
        none      = '0;
        while (counted < budget || plan_engine.phase != PH_IDLE) begin
            b = random_item();
            if (plan_engine.phase == PH_IDLE) begin
                if ($urandom_range(0, 9) == 0) begin
                    b.operation = OP_TICK;
                end else begin
                    b.operation = OP_START;
                    case ($urandom_range(0, 3))
                        0:       ready_pct = 0;
                        1:       ready_pct = 6;
                        2:       ready_pct = 25;
                        default: ready_pct = 60;
                    endcase
                end
            end else if ($urandom_range(0, 24) == 0) begin
                b.operation = OP_START;
            end else begin
                b.operation = OP_TICK;
                if (plan_engine.phase == PH_SYNC)
                    b.lad_in = ($urandom_range(0, 99) < ready_pct) ? SYNC_READY
                                                                   : 4'($urandom_range(1, 15));
            end
            send_beat(b, 1'b0, none);
            counted++;
        end
    endtask

    // Sink side: random stall before each result beat
    initial begin : drive_sink
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = draw_gap(snk_calm);
            if (gap > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    // Check result beats, then predict from accepted input beats
    always @(posedge aclk) begin : watch_beats
        result_t pred;
        result_t w;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (want_beats.size() == 0) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("unexpected result beat: %s", show(m_result));
                end else begin
                    w = want_beats.pop_front();
                    if (m_result.lad_out      !== w.lad_out      ||
                        m_result.lad_drive    !== w.lad_drive    ||
                        m_result.frame_n      !== w.frame_n      ||
                        m_result.busy_res     !== w.busy_res     ||
                        m_result.done_res     !== w.done_res     ||
                        m_result.read_data    !== w.read_data    ||
                        m_result.sync_timeout !== w.sync_timeout) begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS)
                            $display("mismatch: want %s / got %s", show(w), show(m_result));
                    end
                end
            end
            if (s_valid && s_ready) begin
                lpc_cycle_step(mirror_engine, s_item, pred);
                want_beats.push_back(beat_checked ? beat_want : pred);
            end
        end
    end

    initial begin : drive_source
        row_t        rows[$];
        result_t     quiet;
        result_t     tar;
        int unsigned limits[6];
        int          guard;
        plan_engine   = engine_reset();
        mirror_engine = engine_reset();
        quiet = res(4'h0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        tar   = res(NIB_TAR, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);

        // Tick while idle, then an io read at the top address with one wait
        rows.push_back(row(tick_beat(4'h5), 1'b1,
                           res(4'h0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0)));
        rows.push_back(row(start_beat(KIND_IO_RD, 32'hffff_ffff, 8'hff), 1'b1, quiet));
        // Start while busy is dropped
        rows.push_back(row(start_beat(KIND_MEM_WR, 32'h0, 8'h00), 1'b1, quiet));
        rows.push_back(row(tick_beat(4'h0), 1'b1,
                           res(NIB_START, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0)));
        rows.push_back(row(tick_beat(4'h0), 1'b1,
                           res(CT_IO_READ, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0)));
        repeat (4) rows.push_back(row(tick_beat(4'h3), 1'b1, tar));
        repeat (2) rows.push_back(row(tick_beat(4'hc), 1'b1, tar));
        rows.push_back(row(tick_beat(4'hf), 1'b1, quiet));
        rows.push_back(row(tick_beat(SYNC_READY), 1'b1, quiet));
        repeat (2) rows.push_back(row(tick_beat(4'hf), 1'b1, quiet));
        rows.push_back(row(tick_beat(4'h0), 1'b1, quiet));
        rows.push_back(row(tick_beat(4'h0), 1'b1,
                           res(4'h0, 1'b0, 1'b1, 1'b0, 1'b1, 8'hff, 1'b0)));
        // Memory write at address zero; the rest of it runs on into the random part
        rows.push_back(row(start_beat(KIND_MEM_WR, 32'h0, 8'h00), 1'b1, quiet));
        rows.push_back(row(tick_beat(4'ha), 1'b0, quiet));
        rows.push_back(row(tick_beat(4'ha), 1'b1,
                           res(CT_MEM_WRITE, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0)));
        repeat (5) rows.push_back(row(tick_beat(4'h6), 1'b0, quiet));

        limits[0] = 1;
        limits[1] = 255;
        limits[2] = 0;
        limits[3] = $urandom_range(2, 254);
        limits[4] = 3;
        limits[5] = SYNC_LIMIT_RST;

        // Hold reset, then release it at a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) send_beat(rows[i].beat, rows[i].checked, rows[i].want);
        run_random(PHASE_BEATS);
        foreach (limits[i]) begin
            write_limit(8'(limits[i]));
            run_random(PHASE_BEATS);
        end

        // Drain the remaining result beats, then a few quiet cycles
        @(negedge aclk);
        s_valid <= 1'b0;
        guard = 0;
        while (want_beats.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        fault_count += want_beats.size();

        if (fault_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/lhcm_pkg.sv
design/lhcm_front.sv
design/lhcm_engine.sv
design/lpc_host_cycle_master.sv
design/lhcm_checker.sv
tb/tb_top.sv
